/* rtl/core/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros shared by the allocator modules
// Clocked, reset-qualified concurrent assertion wrappers.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every clock edge out of reset
`define SSHA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication
`define SSHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SSHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/ssha_pkg.sv */
// -----------------------------------------------------------------------------
// ssha_pkg
// Sizes, operation and status codes, and controller/datapath link types.
// -----------------------------------------------------------------------------
package ssha_pkg;

    // Table size and derived widths
    localparam int MAX_HANDLES = 64;
    localparam int HANDLE_W    = $clog2(MAX_HANDLES);
    localparam int COUNT_W     = $clog2(MAX_HANDLES + 1);

    // Operation codes
    localparam logic [1:0] MODE_CREATE  = 2'd0;
    localparam logic [1:0] MODE_DESTROY = 2'd1;
    localparam logic [1:0] MODE_LOOKUP  = 2'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_DEAD = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // input word accepted: latch it and issue map reads
        logic execute;   // read data valid: update maps, load result word
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_stall; // result word held and not taken this cycle
    } ctrl_stat_t;

endpackage

/* rtl/core/ssha_ram.sv */
// -----------------------------------------------------------------------------
// ssha_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module ssha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ssha_ctrl.sv */
// -----------------------------------------------------------------------------
// ssha_ctrl
// Two-state sequencer: accept a word and read the maps, then execute it.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssha_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ssha_pkg::ctrl_stat_t stat,
    output ssha_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_accept;

    // Take a word only when the result register can be freed
    assign s_ready  = (state_reg == ST_IDLE) && !stat.out_stall;
    assign s_accept = s_valid && s_ready;

    assign cmd.capture = s_accept;
    assign cmd.execute = (state_reg == ST_EXEC);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SSHA_ASSERT_NEXT(a_accept_exec, aclk, aresetn, s_accept, state_reg == ST_EXEC, "accepted word not executed next cycle")
    `SSHA_ASSERT_NEXT(a_exec_once, aclk, aresetn, state_reg == ST_EXEC, state_reg == ST_IDLE, "execute lasted more than one cycle")

endmodule

/* rtl/core/ssha_datapath.sv */
// -----------------------------------------------------------------------------
// ssha_datapath
// Live bits, live count, handle and slot-owner maps, and the result register.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssha_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ssha_pkg::ctrl_cmd_t           cmd,
    output ssha_pkg::ctrl_stat_t          stat,
    input  logic [1:0]                    s_mode,
    input  logic [ssha_pkg::HANDLE_W-1:0] s_handle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [ssha_pkg::HANDLE_W-1:0] m_new_handle,
    output logic [ssha_pkg::HANDLE_W-1:0] m_dense_slot,
    output logic                          m_moved,
    output logic [ssha_pkg::HANDLE_W-1:0] m_moved_from,
    output logic [ssha_pkg::COUNT_W-1:0]  m_live_count
);

    localparam int HW = ssha_pkg::HANDLE_W;
    localparam int CW = ssha_pkg::COUNT_W;
    localparam int MH = ssha_pkg::MAX_HANDLES;

    // Control state
    logic [MH-1:0] live_reg;
    logic [MH-1:0] live_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    // Captured word
    logic [1:0]    mode_reg;
    logic [HW-1:0] handle_reg;
    logic [HW-1:0] free_reg;
    logic [HW-1:0] last_reg;

    // Result word
    logic [1:0]    status_reg, status_next;
    logic [HW-1:0] new_handle_reg, new_handle_next;
    logic [HW-1:0] slot_reg, slot_next;
    logic          moved_reg, moved_next;
    logic [HW-1:0] from_reg, from_next;

    // RAM ports
    logic          map_we, own_we;
    logic [HW-1:0] map_waddr, map_wdata, own_waddr, own_wdata;
    logic [HW-1:0] map_rdata, own_rdata;
    logic [HW-1:0] last_slot;

    logic          in_range;
    logic          hit;
    logic          do_move;

    // Lowest clear bit of the live vector
    function automatic logic [HW-1:0] first_free(input logic [MH-1:0] live);
        logic [HW-1:0] idx;
        idx = '0;
        for (int i = MH - 1; i >= 0; i--) begin
            if (!live[HW'(i)]) begin
                idx = HW'(i);
            end
        end
        return idx;
    endfunction

    // Slot of the last dense entry; unused while the table is empty
    assign last_slot = count_reg[HW-1:0] - HW'(1);

    // handle -> dense slot
    ssha_ram #(.WIDTH(HW), .DEPTH(MH)) u_map_ram (
        .clk   (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .raddr (s_handle),
        .rdata (map_rdata)
    );

    // dense slot -> owning handle
    ssha_ram #(.WIDTH(HW), .DEPTH(MH)) u_owner_ram (
        .clk   (aclk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .raddr (last_slot),
        .rdata (own_rdata)
    );

    assign in_range = {1'b0, handle_reg} < (HW + 1)'(MH);
    assign hit      = in_range && live_reg[handle_reg];
    assign do_move  = map_rdata < last_reg;

    // Execute: map updates and result word
    always_comb begin
        live_next       = live_reg;
        count_next      = count_reg;
        map_we          = 1'b0;
        map_waddr       = free_reg;
        map_wdata       = count_reg[HW-1:0];
        own_we          = 1'b0;
        own_waddr       = count_reg[HW-1:0];
        own_wdata       = free_reg;
        status_next     = ssha_pkg::STATUS_OK;
        new_handle_next = '0;
        slot_next       = '0;
        moved_next      = 1'b0;
        from_next       = '0;
        if (cmd.execute) begin
            case (mode_reg)
                ssha_pkg::MODE_CREATE: begin
                    if (count_reg == CW'(MH)) begin
                        status_next = ssha_pkg::STATUS_FULL;
                    end else begin
                        map_we              = 1'b1;
                        own_we              = 1'b1;
                        live_next[free_reg] = 1'b1;
                        count_next          = count_reg + CW'(1);
                        new_handle_next     = free_reg;
                        slot_next           = count_reg[HW-1:0];
                    end
                end
                ssha_pkg::MODE_DESTROY: begin
                    if (!hit) begin
                        status_next = ssha_pkg::STATUS_DEAD;
                    end else begin
                        // last entry fills the hole left by this handle
                        if (do_move) begin
                            own_we     = 1'b1;
                            own_waddr  = map_rdata;
                            own_wdata  = own_rdata;
                            map_we     = 1'b1;
                            map_waddr  = own_rdata;
                            map_wdata  = map_rdata;
                            moved_next = 1'b1;
                            from_next  = last_reg;
                        end
                        live_next[handle_reg] = 1'b0;
                        count_next            = count_reg - CW'(1);
                        slot_next             = map_rdata;
                    end
                end
                ssha_pkg::MODE_LOOKUP: begin
                    if (!hit) begin
                        status_next = ssha_pkg::STATUS_DEAD;
                    end else begin
                        slot_next = map_rdata;
                    end
                end
                default: begin
                    // unused code: no operation
                end
            endcase
        end
    end

    // Result register handshake
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.execute) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.out_stall = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            live_reg      <= live_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg   <= s_mode;
            handle_reg <= s_handle;
            free_reg   <= first_free(live_reg);
            last_reg   <= last_slot;
        end
        if (cmd.execute) begin
            status_reg     <= status_next;
            new_handle_reg <= new_handle_next;
            slot_reg       <= slot_next;
            moved_reg      <= moved_next;
            from_reg       <= from_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = status_reg;
    assign m_new_handle = new_handle_reg;
    assign m_dense_slot = slot_reg;
    assign m_moved      = moved_reg;
    assign m_moved_from = from_reg;
    assign m_live_count = count_reg;

    `SSHA_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(MH), "live count above table size")
    `SSHA_ASSERT(a_count_live, aclk, aresetn, $countones(live_reg) == int'(count_reg), "live bits disagree with live count")
    `SSHA_ASSERT_NEXT(a_exec_result, aclk, aresetn, cmd.execute, out_valid_reg, "executed word produced no result")

endmodule

/* rtl/core/sparse_set_handle_allocator.sv */
// -----------------------------------------------------------------------------
// sparse_set_handle_allocator
// Sparse-set handle allocator: create, destroy and look up handles.
// -----------------------------------------------------------------------------
// Input channel s_*: one word per operation, s_mode (create, destroy, lookup)
// and s_handle. Result channel m_*: one word per input word with status,
// granted handle, dense slot, move report and live count after the operation.
// A destroy that is not of the last dense entry reports moved = 1 and the slot
// the last entry came from, so an outside payload memory can copy it.
// A new word is not taken until the last one is executed. An accepted word is
// first latched while the handle and slot-owner RAMs are read (registered read),
// then executed: both maps, the live bits and the count are updated and the
// result word is registered. The next word is taken while a result is still
// held, provided m_ready frees the result register in that cycle.
// Reset (aresetn low, synchronous) clears the live bits, count and valid flag;
// the map RAMs need no clearing since only live entries are read.
// When the receiver stalls, the result word holds and s_ready drops after the
// current word until the result is taken.
// -----------------------------------------------------------------------------
module sparse_set_handle_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_mode,
    input  logic [ssha_pkg::HANDLE_W-1:0] s_handle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [ssha_pkg::HANDLE_W-1:0] m_new_handle,
    output logic [ssha_pkg::HANDLE_W-1:0] m_dense_slot,
    output logic                          m_moved,
    output logic [ssha_pkg::HANDLE_W-1:0] m_moved_from,
    output logic [ssha_pkg::COUNT_W-1:0]  m_live_count
);

    ssha_pkg::ctrl_cmd_t  cmd;
    ssha_pkg::ctrl_stat_t stat;

    // Sequencer
    ssha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Maps, counters and result register
    ssha_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_mode       (s_mode),
        .s_handle     (s_handle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_new_handle (m_new_handle),
        .m_dense_slot (m_dense_slot),
        .m_moved      (m_moved),
        .m_moved_from (m_moved_from),
        .m_live_count (m_live_count)
    );

endmodule
